// ===== sv/mmae_pkg.sv =====
// ----------------------------------------------------------------------------
// mmae_pkg: shared types for the envelope tracker
// Item kinds that the front classifies and the back carries out.
// ----------------------------------------------------------------------------
`default_nettype none

package mmae_pkg;

  // width of the channel field on the input port
  localparam int CHAN_W  = 6;
  // width of a timestamp
  localparam int STAMP_W = 32;
  // width of the kind code in a queue entry
  localparam int KIND_W  = 2;

  // what the back does with an item
  typedef enum logic [KIND_W-1:0] {
    KIND_SAMPLE,
    KIND_CLEAR,
    KIND_SKIP
  } kind_t;

endpackage

`default_nettype wire

// ===== sv/mmae_front.sv =====
// ----------------------------------------------------------------------------
// mmae_front: item classifier
// Decodes the operation, checks the channel range and precomputes the
// widened sample and its saturated magnitude.
// ----------------------------------------------------------------------------
`default_nettype none

module mmae_front import mmae_pkg::*; #(
  parameter int CHANNELS   = 64,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 6
) (
  input  wire logic                         operation,
  input  wire logic [CHAN_W-1:0]            channel,
  input  wire logic signed [31:0]           sample,
  output kind_t                             kind,
  output logic [IDX_W-1:0]                  idx,
  output logic signed [VALUE_BITS-1:0]      value,
  output logic [VALUE_BITS-2:0]             mag
);

  logic [VALUE_BITS-1:0] neg_value;

  // kind of item and channel index
  always_comb begin
    if (operation) begin
      kind = KIND_CLEAR;
    end else if (32'(channel) < 32'(CHANNELS)) begin
      kind = KIND_SAMPLE;
    end else begin
      kind = KIND_SKIP;
    end
    idx = IDX_W'(channel);
  end

  // sample taken to the storage width, two's complement
  assign value     = VALUE_BITS'(sample);
  assign neg_value = VALUE_BITS'(-value);

  // absolute value, saturated at the largest positive value
  always_comb begin
    if (value[VALUE_BITS-1]) begin
      mag = neg_value[VALUE_BITS-1] ? '1 : neg_value[VALUE_BITS-2:0];
    end else begin
      mag = value[VALUE_BITS-2:0];
    end
  end

endmodule

`default_nettype wire

// ===== sv/mmae_queue.sv =====
// ----------------------------------------------------------------------------
// mmae_queue: small item queue
// Flop-based fifo between the front and the back so each side can stall.
// ----------------------------------------------------------------------------
`default_nettype none

module mmae_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  input  wire logic             pop,
  output logic                  head_valid,
  output logic [WIDTH-1:0]      head_data,
  output logic                  full
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] ent [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wr_ptr] <= push_data;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(wr_ptr + 1'b1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : PTR_W'(rd_ptr + 1'b1);
      end
      if (push && !pop) begin
        count <= CNT_W'(count + 1'b1);
      end else if (pop && !push) begin
        count <= CNT_W'(count - 1'b1);
      end
    end
  end

  // head of queue
  assign head_valid = (count != '0);
  assign head_data  = ent[rd_ptr];
  assign full       = (count == CNT_W'(DEPTH));

endmodule

`default_nettype wire

// ===== sv/mmae_back.sv =====
// ----------------------------------------------------------------------------
// mmae_back: envelope update engine
// Reads the channel record, compares and updates the extremes with
// forwarding of the previous write, and holds the result in an output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mmae_back import mmae_pkg::*; #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32,
  parameter int IDX_W      = 6
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          write_enable,
  input  wire logic                          write_data,
  input  wire logic                          head_valid,
  input  wire kind_t                         head_kind,
  input  wire logic [IDX_W-1:0]              head_idx,
  input  wire logic signed [VALUE_BITS-1:0]  head_value,
  input  wire logic [VALUE_BITS-2:0]         head_mag,
  input  wire logic [STAMP_W-1:0]            head_stamp,
  output logic                               pop,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [31:0]                 low_value,
  output logic signed [31:0]                 high_value,
  output logic [30:0]                        peak_magnitude,
  output logic [STAMP_W-1:0]                 low_stamp,
  output logic [STAMP_W-1:0]                 high_stamp,
  output logic [STAMP_W-1:0]                 peak_stamp,
  output logic                               changed
);

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] lo;
    logic signed [VALUE_BITS-1:0] hi;
    logic [VALUE_BITS-2:0]        pk;
    logic [STAMP_W-1:0]           t_lo;
    logic [STAMP_W-1:0]           t_hi;
    logic [STAMP_W-1:0]           t_pk;
  } rec_t;

  rec_t                         mem [DEPTH];
  rec_t                         rd_rec;
  rec_t                         fwd_rec;
  rec_t                         cur;
  rec_t                         upd;
  logic                         fwd_hit;
  logic [DEPTH-1:0]             seen;
  logic                         time_echo;

  logic                         e_valid;
  kind_t                        e_kind;
  logic [IDX_W-1:0]             e_idx;
  logic signed [VALUE_BITS-1:0] e_value;
  logic [VALUE_BITS-2:0]        e_mag;
  logic [STAMP_W-1:0]           e_stamp;

  logic                         e_fire;
  logic                         e_sample;
  logic                         chg;
  logic                         pk_up;

  // handshake between the stages
  assign e_fire   = e_valid && (!out_valid || !out_stall);
  assign pop      = head_valid && (!e_valid || e_fire);
  assign e_sample = (e_kind == KIND_SAMPLE);

  // echo register
  always_ff @(posedge clk) begin
    if (rst) begin
      time_echo <= 1'b0;
    end else if (write_enable) begin
      time_echo <= write_data;
    end
  end

  // record memory, registered read on pop
  always_ff @(posedge clk) begin
    if (e_fire && e_sample) begin
      mem[e_idx] <= upd;
    end
    if (pop) begin
      rd_rec <= mem[head_idx];
    end
  end

  // bypass of the record written in the same cycle as the read
  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_hit <= 1'b0;
    end else if (pop) begin
      fwd_hit <= e_fire && e_sample && (e_idx == head_idx);
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      fwd_rec <= upd;
    end
  end

  // update stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (pop) begin
      e_valid <= 1'b1;
    end else if (e_fire) begin
      e_valid <= 1'b0;
    end
  end

  // update stage payload
  always_ff @(posedge clk) begin
    if (pop) begin
      e_kind  <= head_kind;
      e_idx   <= head_idx;
      e_value <= head_value;
      e_mag   <= head_mag;
      e_stamp <= head_stamp;
    end
  end

  // compare and update of the extremes
  always_comb begin
    cur   = fwd_hit ? fwd_rec : rd_rec;
    upd   = cur;
    chg   = 1'b0;
    pk_up = (e_mag > cur.pk);
    if (!seen[e_idx]) begin
      upd.lo   = e_value;
      upd.hi   = e_value;
      upd.pk   = e_mag;
      upd.t_lo = e_stamp;
      upd.t_hi = e_stamp;
      upd.t_pk = e_stamp;
      chg      = 1'b1;
    end else if (e_value < cur.lo) begin
      upd.lo   = e_value;
      upd.t_lo = e_stamp;
      if (pk_up) begin
        upd.pk   = e_mag;
        upd.t_pk = e_stamp;
      end
      chg = 1'b1;
    end else if (e_value > cur.hi) begin
      upd.hi   = e_value;
      upd.t_hi = e_stamp;
      if (pk_up) begin
        upd.pk   = e_mag;
        upd.t_pk = e_stamp;
      end
      chg = 1'b1;
    end
  end

  // seen bits, cleared at once by a clear item
  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= '0;
    end else if (e_fire) begin
      if (e_kind == KIND_CLEAR) begin
        seen <= '0;
      end else if (e_sample) begin
        seen[e_idx] <= 1'b1;
      end
    end
  end

  // output stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (e_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // output stage payload, zero for clear and out-of-range items
  always_ff @(posedge clk) begin
    if (e_fire) begin
      if (e_sample) begin
        low_value      <= 32'(upd.lo);
        high_value     <= 32'(upd.hi);
        peak_magnitude <= 31'(upd.pk);
        low_stamp      <= time_echo ? upd.t_lo : '0;
        high_stamp     <= time_echo ? upd.t_hi : '0;
        peak_stamp     <= time_echo ? upd.t_pk : '0;
        changed        <= chg;
      end else begin
        low_value      <= '0;
        high_value     <= '0;
        peak_magnitude <= '0;
        low_stamp      <= '0;
        high_stamp     <= '0;
        peak_stamp     <= '0;
        changed        <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/min_max_absmax_envelope_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// min_max_absmax_envelope_tracker_unit: per-channel min, max and peak tracker
// Path: queue entry, then update stage, then output stage, each registered.
// Throughput: 1 item per cycle while out_stall is low, set by the record
// read-modify-write loop, closed by forwarding of the last written record.
// Reset: seen bits, queue, stages and echo register are cleared;
// record memory is not cleared, every entry is written before it is used.
// ----------------------------------------------------------------------------
`default_nettype none

module min_max_absmax_envelope_tracker_unit import mmae_pkg::*; #(
  parameter int CHANNELS   = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                write_enable,
  input  wire logic                write_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic                operation,
  input  wire logic [CHAN_W-1:0]   channel,
  input  wire logic signed [31:0]  sample,
  input  wire logic [STAMP_W-1:0]  stamp,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [31:0]       low_value,
  output logic signed [31:0]       high_value,
  output logic [30:0]              peak_magnitude,
  output logic [STAMP_W-1:0]       low_stamp,
  output logic [STAMP_W-1:0]       high_stamp,
  output logic [STAMP_W-1:0]       peak_stamp,
  output logic                     changed
);

  // only channels the input field can name get storage
  localparam int REACH  = 1 << CHAN_W;
  localparam int DEPTH  = (CHANNELS < REACH) ? CHANNELS : REACH;
  localparam int IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int ITEM_W = KIND_W + IDX_W + VALUE_BITS + (VALUE_BITS - 1) + STAMP_W;
  localparam int QDEPTH = 2;

  kind_t                        f_kind;
  logic [IDX_W-1:0]             f_idx;
  logic signed [VALUE_BITS-1:0] f_value;
  logic [VALUE_BITS-2:0]        f_mag;

  logic                         push;
  logic                         pop;
  logic                         q_full;
  logic                         head_valid;
  logic [ITEM_W-1:0]            push_data;
  logic [ITEM_W-1:0]            head_data;

  kind_t                        h_kind;
  logic [IDX_W-1:0]             h_idx;
  logic signed [VALUE_BITS-1:0] h_value;
  logic [VALUE_BITS-2:0]        h_mag;
  logic [STAMP_W-1:0]           h_stamp;

  // front: classify the incoming item
  mmae_front #(
    .CHANNELS   (CHANNELS),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W)
  ) u_front (
    .operation (operation),
    .channel   (channel),
    .sample    (sample),
    .kind      (f_kind),
    .idx       (f_idx),
    .value     (f_value),
    .mag       (f_mag)
  );

  // input handshake
  assign in_stall  = q_full;
  assign push      = in_valid && !q_full;
  assign push_data = {f_kind, f_idx, f_value, f_mag, stamp};

  // queue between front and back
  mmae_queue #(
    .WIDTH (ITEM_W),
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_data  (push_data),
    .pop        (pop),
    .head_valid (head_valid),
    .head_data  (head_data),
    .full       (q_full)
  );

  // unpack queue head
  assign h_kind  = kind_t'(head_data[ITEM_W-1 -: KIND_W]);
  assign h_idx   = head_data[ITEM_W-KIND_W-1 -: IDX_W];
  assign h_value = head_data[ITEM_W-KIND_W-IDX_W-1 -: VALUE_BITS];
  assign h_mag   = head_data[STAMP_W +: (VALUE_BITS - 1)];
  assign h_stamp = head_data[STAMP_W-1:0];

  // back: record update and result stage
  mmae_back #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS),
    .IDX_W      (IDX_W)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .write_enable   (write_enable),
    .write_data     (write_data),
    .head_valid     (head_valid),
    .head_kind      (h_kind),
    .head_idx       (h_idx),
    .head_value     (h_value),
    .head_mag       (h_mag),
    .head_stamp     (h_stamp),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .low_value      (low_value),
    .high_value     (high_value),
    .peak_magnitude (peak_magnitude),
    .low_stamp      (low_stamp),
    .high_stamp     (high_stamp),
    .peak_stamp     (peak_stamp),
    .changed        (changed)
  );

endmodule

`default_nettype wire

// ===== tb/sv/envelope_tb_pkg.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// envelope_tb_pkg: shared codes for the envelope tracker testbench
// Item operation codes and the channel count that stimulus and comparison
// both rely on.
// ----------------------------------------------------------------------------

package envelope_tb_pkg;

  // channels held by the block under test
  localparam int NUM_CHANNELS = 64;

  // operation field of an input item
  typedef enum logic {
    OP_SAMPLE = 1'b0,
    OP_CLEAR  = 1'b1
  } op_t;

endpackage

// ===== tb/sv/envelope_compare.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// envelope_compare: prediction and comparison for the envelope tracker
// Watches both item channels and the echo register port, keeps its own
// per-channel min, max and peak records, queues the envelope due for every
// accepted input item and compares each accepted result field by field.
// ----------------------------------------------------------------------------

module envelope_compare import mmae_pkg::*; import envelope_tb_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     write_enable,
  input  logic                     write_data,
  input  logic                     in_valid,
  input  logic                     in_stall,
  input  logic                     operation,
  input  logic [CHAN_W-1:0]        channel,
  input  logic signed [31:0]       sample,
  input  logic [STAMP_W-1:0]       stamp,
  input  logic                     out_valid,
  input  logic                     out_stall,
  input  logic signed [31:0]       low_value,
  input  logic signed [31:0]       high_value,
  input  logic [30:0]              peak_magnitude,
  input  logic [STAMP_W-1:0]       low_stamp,
  input  logic [STAMP_W-1:0]       high_stamp,
  input  logic [STAMP_W-1:0]       peak_stamp,
  input  logic                     changed,
  output int                       fail_count,
  output int                       results_owed
);

  typedef struct {
    logic signed [31:0]  low;
    logic signed [31:0]  high;
    logic [30:0]         peak;
    logic [STAMP_W-1:0]  low_t;
    logic [STAMP_W-1:0]  high_t;
    logic [STAMP_W-1:0]  peak_t;
    logic                chg;
  } envelope_t;

  // per-channel records and the echo register
  bit [NUM_CHANNELS-1:0] seen;
  logic signed [31:0]    low_rec   [NUM_CHANNELS];
  logic signed [31:0]    high_rec  [NUM_CHANNELS];
  logic [30:0]           peak_rec  [NUM_CHANNELS];
  logic [STAMP_W-1:0]    low_when  [NUM_CHANNELS];
  logic [STAMP_W-1:0]    high_when [NUM_CHANNELS];
  logic [STAMP_W-1:0]    peak_when [NUM_CHANNELS];
  logic                  echo_on;

  envelope_t envelope_due [$];
  envelope_t want;

  // apply one item to the records and return the envelope it reports
  function automatic envelope_t envelope_after(logic op, logic [CHAN_W-1:0] ch,
                                               logic signed [31:0] v,
                                               logic [STAMP_W-1:0] t);
    envelope_t r;
    logic [31:0] mag;
    logic [30:0] a;
    r.low = '0; r.high = '0; r.peak = '0;
    r.low_t = '0; r.high_t = '0; r.peak_t = '0;
    r.chg = 1'b0;
    if (op == OP_CLEAR) begin
      seen = '0;
      return r;
    end
    // absolute value, most negative saturates
    mag = v[31] ? 32'(-v) : 32'(v);
    a = (mag > 32'h7fff_ffff) ? 31'h7fff_ffff : mag[30:0];
    if (!seen[ch]) begin
      seen[ch] = 1'b1;
      low_rec[ch] = v;
      high_rec[ch] = v;
      peak_rec[ch] = a;
      low_when[ch] = t;
      high_when[ch] = t;
      peak_when[ch] = t;
      r.chg = 1'b1;
    end else if (v < low_rec[ch]) begin
      low_rec[ch] = v;
      low_when[ch] = t;
      if (a > peak_rec[ch]) begin
        peak_rec[ch] = a;
        peak_when[ch] = t;
      end
      r.chg = 1'b1;
    end else if (v > high_rec[ch]) begin
      high_rec[ch] = v;
      high_when[ch] = t;
      if (a > peak_rec[ch]) begin
        peak_rec[ch] = a;
        peak_when[ch] = t;
      end
      r.chg = 1'b1;
    end
    r.low = low_rec[ch];
    r.high = high_rec[ch];
    r.peak = peak_rec[ch];
    // stamps are always kept, echo only gates the outputs
    if (echo_on) begin
      r.low_t = low_when[ch];
      r.high_t = high_when[ch];
      r.peak_t = peak_when[ch];
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] got_v);
    if (got_v !== exp_v) begin
      if (fail_count < 10)
        $display("%0t: %s mismatch, expected %h got %h", $realtime, name, exp_v, got_v);
      fail_count++;
    end
  endfunction

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      seen = '0;
      echo_on = 1'b0;
      envelope_due.delete();
      fail_count = 0;
    end else begin
      if (write_enable)
        echo_on = write_data;
      if (out_valid && !out_stall) begin
        if (envelope_due.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with no item outstanding, low %h high %h", $realtime,
                     low_value, high_value);
          fail_count++;
        end else begin
          want = envelope_due.pop_front();
          check_field("low_value", want.low, low_value);
          check_field("high_value", want.high, high_value);
          check_field("peak_magnitude", 32'(want.peak), 32'(peak_magnitude));
          check_field("low_stamp", want.low_t, low_stamp);
          check_field("high_stamp", want.high_t, high_stamp);
          check_field("peak_stamp", want.peak_t, peak_stamp);
          check_field("changed", 32'(want.chg), 32'(changed));
        end
      end
      if (in_valid && !in_stall)
        envelope_due.push_back(envelope_after(operation, channel, sample, stamp));
    end
    results_owed = envelope_due.size();
  end

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top level testbench for the envelope tracker
// Drives directed corner items, then three random phases with different
// sender and receiver idle rates and echo settings, including one long
// receiver hold-off that backs the block up. Comparison is done beside the
// block; this module drives items and receiver stalls and reports the verdict.
// ----------------------------------------------------------------------------

module tb;
  import mmae_pkg::*;
  import envelope_tb_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 150;
  localparam int PHASE_ITEMS = 300;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                write_enable;
  logic                write_data;
  logic                in_valid;
  logic                in_stall;
  logic                operation;
  logic [CHAN_W-1:0]   channel;
  logic signed [31:0]  sample;
  logic [STAMP_W-1:0]  stamp;
  logic                out_valid;
  logic                out_stall;
  logic signed [31:0]  low_value;
  logic signed [31:0]  high_value;
  logic [30:0]         peak_magnitude;
  logic [STAMP_W-1:0]  low_stamp;
  logic [STAMP_W-1:0]  high_stamp;
  logic [STAMP_W-1:0]  peak_stamp;
  logic                changed;
  int                  fail_count;
  int                  results_owed;

  int                  send_idle_pct;
  int                  recv_stall_pct;
  bit                  hold_req;
  int                  quiet_cycles = 0;
  logic signed [31:0]  last_val [NUM_CHANNELS];

  always #4 clk = ~clk;

  min_max_absmax_envelope_tracker_unit uut (.*);

  envelope_compare env_cmp (.*);

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("min_max_absmax_envelope_tracker_unit test failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_taken;
    hold_left = 0;
    hold_taken = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // offer one item, hold it until accepted; starts and ends at a falling edge
  task automatic push_item(input op_t op, input logic [CHAN_W-1:0] ch,
                           input logic [31:0] val, input logic [STAMP_W-1:0] st);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    operation <= op;
    channel <= ch;
    sample <= val;
    stamp <= st;
    @(posedge clk);
    while (in_stall)
      @(posedge clk);
    @(negedge clk);
  endtask

  // stop offering and wait for every result to come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_owed != 0)
      @(negedge clk);
  endtask

  task automatic set_echo(input logic on);
    write_enable <= 1'b1;
    write_data <= on;
    @(negedge clk);
    write_enable <= 1'b0;
  endtask

  // drifting samples, mostly on a few busy channels, some corners, rare clears
  task automatic random_item();
    int pick;
    logic [CHAN_W-1:0] ch;
    logic [31:0] val;
    pick = $urandom_range(99);
    ch = ($urandom_range(99) < 70) ? CHAN_W'($urandom_range(7)) : CHAN_W'($urandom_range(63));
    if (pick < 3) begin
      push_item(OP_CLEAR, ch, $urandom, $urandom);
    end else begin
      if (pick < 13) begin
        case ($urandom_range(5))
          0: val = 32'h8000_0000;
          1: val = 32'h8000_0001;
          2: val = 32'h7fff_ffff;
          3: val = 32'hffff_ffff;
          4: val = 32'h0000_0001;
          default: val = 32'h0000_0000;
        endcase
      end else if (pick < 60) begin
        val = last_val[ch] + 32'($urandom_range(262144)) - 32'd131072;
      end else if (pick < 75) begin
        val = 32'($urandom_range(2000)) - 32'd1000;
      end else begin
        val = $urandom;
      end
      last_val[ch] = val;
      push_item(OP_SAMPLE, ch, val, $urandom);
    end
  endtask

  task automatic run_phase(input logic echo, input int idle_pct, input int stall_pct,
                           input int hold_at);
    wait_drained();
    set_echo(echo);
    send_idle_pct = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i == hold_at)
        hold_req = 1'b1;
      random_item();
    end
  endtask

  initial begin : stimulus
    write_enable = 1'b0;
    write_data = 1'b0;
    in_valid = 1'b0;
    operation = OP_SAMPLE;
    channel = '0;
    sample = '0;
    stamp = '0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req = 1'b0;
    foreach (last_val[i])
      last_val[i] = '0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    set_echo(1'b0);

    // directed corners with echo off
    push_item(OP_SAMPLE, 6'd0, 32'h0000_0000, 32'h0000_0000);   // first sample sets all
    push_item(OP_SAMPLE, 6'd0, 32'h0000_0000, 32'h0000_0001);   // equal, no change
    push_item(OP_SAMPLE, 6'd0, 32'h7fff_ffff, 32'hffff_ffff);   // new max and peak
    push_item(OP_SAMPLE, 6'd0, 32'h8000_0000, 32'h0000_0002);   // new min, saturated abs
    push_item(OP_SAMPLE, 6'd0, 32'h8000_0000, 32'h0000_0003);   // equal min
    push_item(OP_SAMPLE, 6'd0, 32'h7fff_ffff, 32'h0000_0004);   // equal max
    push_item(OP_SAMPLE, 6'd63, 32'h8000_0000, 32'h0000_0005);  // first sample most negative
    push_item(OP_SAMPLE, 6'd63, 32'hffff_ffff, 32'h0000_0006);  // new max, peak stays
    push_item(OP_SAMPLE, 6'd63, 32'h0000_0000, 32'h0000_0007);
    push_item(OP_SAMPLE, 6'd21, 32'hffff_fffb, 32'h0000_0008);  // -5
    push_item(OP_SAMPLE, 6'd21, 32'h0000_0003, 32'h0000_0009);  // new max, smaller abs
    push_item(OP_SAMPLE, 6'd21, 32'h0000_0009, 32'h0000_000a);  // new max, bigger abs
    push_item(OP_SAMPLE, 6'd21, 32'hffff_ffec, 32'h0000_000b);  // new min, bigger abs
    push_item(OP_SAMPLE, 6'd21, 32'h0000_0001, 32'h0000_000c);  // inside envelope
    push_item(OP_CLEAR, 6'h3f, 32'hffff_ffff, 32'hffff_ffff);   // clear all channels
    push_item(OP_SAMPLE, 6'd0, 32'h0001_0000, 32'h8000_0000);   // channel starts over
    push_item(OP_SAMPLE, 6'd63, 32'h7fff_ffff, 32'h5555_5555);
    push_item(OP_CLEAR, 6'd0, 32'h0000_0000, 32'h0000_0000);
    push_item(OP_SAMPLE, 6'd42, 32'h8000_0001, 32'haaaa_aaaa);  // abs is largest positive
    push_item(OP_SAMPLE, 6'd42, 32'h8000_0000, 32'h0000_000d);  // lower min, peak equal
    push_item(OP_SAMPLE, 6'd42, 32'h7fff_ffff, 32'h0000_000e);  // new max, peak equal

    // random phases: slow receiver, slow sender, then full rate with a hold-off
    run_phase(1'b1, 22, 70, -1);
    run_phase(1'b0, 70, 22, -1);
    run_phase(1'b1, 0, 0, 100);

    wait_drained();
    repeat (8) @(negedge clk);
    if (fail_count == 0)
      $display("min_max_absmax_envelope_tracker_unit test passed");
    else
      $display("min_max_absmax_envelope_tracker_unit test failed");
    $finish;
  end

endmodule
